FILE: sv/cnv_pkg.sv
package cnv_pkg;

   localparam int MAX_KERNEL     = 7;
   localparam int MAX_WIDTH      = 1024;
   localparam int COEF_FRAC_BITS = 8;
   localparam int PIX_MAX        = 255;

   localparam int STORE_ROWS = MAX_KERNEL + 1;
   localparam int SLOT_W     = $clog2(STORE_ROWS);
   localparam int CTR        = MAX_KERNEL / 2;
   localparam int PAD_W      = $clog2(CTR + 1);
   localparam int COEF_NUM   = MAX_KERNEL * MAX_KERNEL;

   localparam int KER_W  = 3;
   localparam int WID_W  = 11;
   localparam int HGT_W  = 16;
   localparam int CIDX_W = 6;
   localparam int COEF_W = 16;
   localparam int PIX_W  = 8;
   localparam int RGB_W  = 3 * PIX_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);

   localparam int PROD_W = COEF_W + PIX_W + 1;
   localparam int RSUM_W = PROD_W + $clog2(MAX_KERNEL);
   localparam int SUM_W  = RSUM_W + $clog2(MAX_KERNEL);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int FIFO_DEPTH  = 8;
   localparam int FPTR_W      = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_PIXEL = 2'd1,
      REQ_DRAIN = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [CIDX_W-1:0]       coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic [PIX_W-1:0]        in_red;
      logic [PIX_W-1:0]        in_green;
      logic [PIX_W-1:0]        in_blue;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic [KER_W-1:0] kernel;
      logic [PAD_W-1:0] pad;
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic                     do_load;
      logic                     do_write;
      logic                     do_emit;
      logic [CIDX_W-1:0]        coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic [RGB_W-1:0]         pixel;
      logic [SLOT_W-1:0]        wr_slot;
      logic [COL_W-1:0]         wr_col;
      logic [HGT_W-1:0]         ey;
      logic [COL_W-1:0]         ex;
      logic                     last;
   } cmd_type;

   typedef struct packed {
      logic                     valid;
      logic [CIDX_W-1:0]        index;
      logic signed [COEF_W-1:0] value;
   } load_type;

   typedef struct packed {
      logic valid;
      logic last;
   } emit_type;

   typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][RGB_W-1:0] win_type;

   // Kernel table slot for window position (j,i); rows are centered, columns
   // right-aligned (newest column at the right edge); msb flags a live tap.
   function automatic logic [CIDX_W:0] coef_slot(input int j, input int i,
                                                 input logic [KER_W-1:0] k);
      int pad;
      int dy;
      int dx;
      int idx;
      logic [CIDX_W:0] res;
      pad = int'(k >> 1);
      dy  = j - CTR;
      dx  = i - (MAX_KERNEL - 1) + pad;
      res = '0;
      if (dy >= -pad && dy <= pad && dx >= -pad && dx <= pad) begin
         idx = (dy + pad) * int'(k) + dx + pad;
         res = {1'b1, idx[CIDX_W-1:0]};
      end
      return res;
   endfunction

endpackage

FILE: sv/cnv_ram.sv
module cnv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cnv_front.sv
module cnv_front (
   input  logic                   clock,
   input  logic                   reset,
   input  cnv_pkg::geom_type      geom,
   input  logic                   req_push,
   output logic                   req_full,
   input  cnv_pkg::req_word_type  req_data,
   output logic                   cmd_valid,
   output cnv_pkg::cmd_type       cmd_head,
   input  logic                   cmd_pop
);

   // frame position of the next input pixel and of the next output
   logic [cnv_pkg::WID_W-1:0] col_ff, col_in;
   logic [cnv_pkg::HGT_W-1:0] row_ff, row_in;
   logic [cnv_pkg::HGT_W-1:0] ey_ff, ey_in;
   logic [cnv_pkg::COL_W-1:0] ex_ff, ex_in;

   cnv_pkg::cmd_type            q_ff [cnv_pkg::QUEUE_DEPTH];
   logic [cnv_pkg::QPTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [cnv_pkg::QPTR_W:0]    cnt_ff, cnt_in;

   cnv_pkg::req_kind_type     kind;
   logic                      is_load, is_pixel, is_drain, new_frame;
   logic [cnv_pkg::WID_W-1:0] c1, c2, c3, c4, nx, wm1, ex_n;
   logic [cnv_pkg::HGT_W:0]   r1, r2, r4, ny;
   logic [cnv_pkg::HGT_W-1:0] hm1, ey_b, ey_n;
   logic [cnv_pkg::COL_W-1:0] ex_b;
   logic                      ready, emit, accept, enq, deq;
   cnv_pkg::cmd_type          cmd;

   always_comb begin
      kind     = cnv_pkg::req_kind_type'(req_data.req_type);
      is_load  = (kind == cnv_pkg::REQ_LOAD);
      is_pixel = (kind == cnv_pkg::REQ_PIXEL);
      is_drain = (kind == cnv_pkg::REQ_DRAIN);
      hm1      = geom.height - 16'd1;
      wm1      = geom.width - 11'd1;

      // row wrap before the write, new frame once the old one is complete
      new_frame = 1'b0;
      c1 = col_ff;
      r1 = {1'b0, row_ff};
      if (col_ff >= geom.width) begin
         c1 = '0;
         r1 = {1'b0, row_ff} + 17'd1;
      end
      c2 = c1;
      r2 = r1;
      if (r1 >= {1'b0, geom.height}) begin
         c2 = '0;
         r2 = '0;
         new_frame = 1'b1;
      end
      c3 = c2 + 11'd1;
      c4 = c3;
      r4 = r2;
      if (c3 >= geom.width) begin
         c4 = '0;
         r4 = r2 + 17'd1;
      end
      if (!is_pixel) begin
         c4 = col_ff;
         r4 = {1'b0, row_ff};
         new_frame = 1'b0;
      end

      ey_b = new_frame ? '0 : ey_ff;
      ex_b = new_frame ? '0 : ex_ff;

      // lower right corner of the window, clipped to the frame
      ny = {1'b0, ey_b} + 17'(geom.pad);
      if (ny > {1'b0, hm1}) begin
         ny = {1'b0, hm1};
      end
      nx = {1'b0, ex_b} + 11'(geom.pad);
      if (nx > wm1) begin
         nx = wm1;
      end
      ready = 1'b1;
      if (r4 < {1'b0, geom.height}) begin
         ready = (ny < r4) || (ny == r4 && nx < c4);
      end
      emit = (is_pixel || is_drain) && (ey_b < geom.height) && ready;

      ex_n = {1'b0, ex_b} + 11'd1;
      ey_n = ey_b;
      if (ex_n >= geom.width) begin
         ex_n = '0;
         ey_n = ey_b + 16'd1;
      end

      cmd.do_load    = is_load && (req_data.coef_index < 6'(cnv_pkg::COEF_NUM));
      cmd.do_write   = is_pixel;
      cmd.do_emit    = emit;
      cmd.coef_index = req_data.coef_index;
      cmd.coef_value = req_data.coef_value;
      cmd.pixel      = {req_data.in_red, req_data.in_green, req_data.in_blue};
      cmd.wr_slot    = r2[cnv_pkg::SLOT_W-1:0];
      cmd.wr_col     = c2[cnv_pkg::COL_W-1:0];
      cmd.ey         = ey_b;
      cmd.ex         = ex_b;
      cmd.last       = (ey_b == hm1) && ({1'b0, ex_b} == wm1);

      req_full = (cnt_ff == (cnv_pkg::QPTR_W + 1)'(cnv_pkg::QUEUE_DEPTH));
      accept   = req_push && !req_full;
      enq      = accept && (cmd.do_load || cmd.do_write || cmd.do_emit);
      deq      = cmd_pop && (cnt_ff != '0);

      col_in = col_ff;
      row_in = row_ff;
      ey_in  = ey_ff;
      ex_in  = ex_ff;
      if (accept && is_pixel) begin
         col_in = c4;
         row_in = r4[cnv_pkg::HGT_W-1:0];
         ey_in  = ey_b;
         ex_in  = ex_b;
      end
      if (accept && emit) begin
         ey_in = ey_n;
         ex_in = ex_n[cnv_pkg::COL_W-1:0];
      end

      head_in = deq ? head_ff + 1'b1 : head_ff;
      tail_in = enq ? tail_ff + 1'b1 : tail_ff;
      cnt_in  = cnt_ff + (cnv_pkg::QPTR_W + 1)'(enq) - (cnv_pkg::QPTR_W + 1)'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ey_ff   <= '0;
         ex_ff   <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ey_ff   <= ey_in;
         ex_ff   <= ex_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[tail_ff] <= cmd;
      end
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd_head  = q_ff[head_ff];

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (cnv_pkg::QPTR_W + 1)'(cnv_pkg::QUEUE_DEPTH))
      else $error("command queue overrun");

endmodule

FILE: sv/cnv_window.sv
module cnv_window (
   input  logic                      clock,
   input  logic                      reset,
   input  cnv_pkg::geom_type         geom,
   input  logic                      cmd_valid,
   input  cnv_pkg::cmd_type          cmd_head,
   output logic                      cmd_pop,
   input  logic [cnv_pkg::FPTR_W:0]  mac_occ,
   output cnv_pkg::load_type         load,
   output cnv_pkg::emit_type         emit,
   output cnv_pkg::win_type          win
);

   // fetch sequencer: one line-store column per cycle while the result queue has room
   logic [cnv_pkg::PAD_W-1:0]  cnt_ff, cnt_in;
   logic                       row_start, first, fin, room, go, we, hit;
   logic [cnv_pkg::COL_W:0]    fetch_col;
   logic [cnv_pkg::FPTR_W+1:0] pend;
   logic [cnv_pkg::STORE_ROWS-1:0] ram_we;
   logic [cnv_pkg::RGB_W-1:0]  rd_data [cnv_pkg::STORE_ROWS];

   // column stage, lined up with the registered store read
   logic                       b_fetch_ff, b_emit_ff, b_clear_ff;
   logic                       b_last_ff, b_colok_ff, b_hit_ff;
   logic [cnv_pkg::HGT_W-1:0]  b_ey_ff;
   logic [cnv_pkg::SLOT_W-1:0] b_slot_ff;
   logic [cnv_pkg::RGB_W-1:0]  b_pix_ff;
   cnv_pkg::load_type          b_load_ff, b_load_in;

   cnv_pkg::win_type           win_ff, win_in;
   cnv_pkg::emit_type          win_emit_ff;

   logic [cnv_pkg::SLOT_W-1:0] slot;
   logic [cnv_pkg::HGT_W+1:0]  sy;
   logic [cnv_pkg::RGB_W-1:0]  sample;

   // row start fetches columns 0..pad, later outputs fetch column ex+pad
   always_comb begin
      row_start = (cmd_head.ex == '0);
      first     = (cnt_ff == '0);
      fin       = !row_start || (cnt_ff == geom.pad);
      pend      = (cnv_pkg::FPTR_W + 2)'(mac_occ) + (cnv_pkg::FPTR_W + 2)'(b_emit_ff)
                + (cnv_pkg::FPTR_W + 2)'(win_emit_ff.valid);
      room      = pend < (cnv_pkg::FPTR_W + 2)'(cnv_pkg::FIFO_DEPTH);
      go        = cmd_valid && (!cmd_head.do_emit || room);
      cmd_pop   = go && (!cmd_head.do_emit || fin);
      cnt_in    = cnt_ff;
      if (go && cmd_head.do_emit) begin
         cnt_in = fin ? '0 : cnt_ff + 1'b1;
      end
      fetch_col = row_start ? (cnv_pkg::COL_W + 1)'(cnt_ff)
                            : {1'b0, cmd_head.ex} + (cnv_pkg::COL_W + 1)'(geom.pad);
      we        = go && first && cmd_head.do_write;
      hit       = we && !fetch_col[cnv_pkg::COL_W]
                && (cmd_head.wr_col == fetch_col[cnv_pkg::COL_W-1:0]);
      for (int s = 0; s < cnv_pkg::STORE_ROWS; s++) begin
         ram_we[s] = we && (cmd_head.wr_slot == cnv_pkg::SLOT_W'(s));
      end
      b_load_in.valid = go && first && cmd_head.do_load;
      b_load_in.index = cmd_head.coef_index;
      b_load_in.value = cmd_head.coef_value;
   end

   for (genvar s = 0; s < cnv_pkg::STORE_ROWS; s++) begin : g_slot
      cnv_ram #(
         .WIDTH(cnv_pkg::RGB_W),
         .DEPTH(cnv_pkg::MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[s]),
         .wr_addr (cmd_head.wr_col),
         .wr_data (cmd_head.pixel),
         .rd_addr (fetch_col[cnv_pkg::COL_W-1:0]),
         .rd_data (rd_data[s])
      );
   end

   // shift the fetched column in at the right edge; row start clears first
   always_comb begin
      win_in = win_ff;
      for (int j = 0; j < cnv_pkg::MAX_KERNEL; j++) begin
         slot   = b_ey_ff[cnv_pkg::SLOT_W-1:0] + cnv_pkg::SLOT_W'(j)
                - cnv_pkg::SLOT_W'(cnv_pkg::CTR);
         sy     = {2'b00, b_ey_ff} + (cnv_pkg::HGT_W + 2)'(j);
         sample = rd_data[slot];
         if (b_hit_ff && slot == b_slot_ff) begin
            sample = b_pix_ff;
         end
         if (!b_colok_ff || sy < (cnv_pkg::HGT_W + 2)'(cnv_pkg::CTR)
             || (sy - (cnv_pkg::HGT_W + 2)'(cnv_pkg::CTR)) >= {2'b00, geom.height}) begin
            sample = '0;
         end
         if (b_fetch_ff) begin
            for (int i = 0; i < cnv_pkg::MAX_KERNEL - 1; i++) begin
               win_in[j][i] = b_clear_ff ? '0 : win_ff[j][i+1];
            end
            win_in[j][cnv_pkg::MAX_KERNEL-1] = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff            <= '0;
         b_fetch_ff        <= 1'b0;
         b_emit_ff         <= 1'b0;
         b_clear_ff        <= 1'b0;
         b_hit_ff          <= 1'b0;
         b_load_ff.valid   <= 1'b0;
         win_emit_ff.valid <= 1'b0;
      end else begin
         cnt_ff            <= cnt_in;
         b_fetch_ff        <= go && cmd_head.do_emit;
         b_emit_ff         <= go && cmd_head.do_emit && fin;
         b_clear_ff        <= go && cmd_head.do_emit && row_start && first;
         b_hit_ff          <= hit;
         b_load_ff.valid   <= b_load_in.valid;
         win_emit_ff.valid <= b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_last_ff         <= cmd_head.last;
      b_ey_ff           <= cmd_head.ey;
      b_colok_ff        <= fetch_col < geom.width;
      b_slot_ff         <= cmd_head.wr_slot;
      b_pix_ff          <= cmd_head.pixel;
      b_load_ff.index   <= b_load_in.index;
      b_load_ff.value   <= b_load_in.value;
      win_emit_ff.last  <= b_last_ff;
      win_ff            <= win_in;
   end

   assign load = b_load_ff;
   assign emit = win_emit_ff;
   assign win  = win_ff;

   a_seq_holds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (cmd_valid && cmd_head.do_emit))
      else $error("row-start fetch lost its command");

   a_clear_fetch: assert property (@(posedge clock) disable iff (reset)
      b_clear_ff |-> b_fetch_ff)
      else $error("window clear without a column fetch");

endmodule

FILE: sv/cnv_mac.sv
module cnv_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  cnv_pkg::geom_type         geom,
   input  cnv_pkg::load_type         load,
   input  cnv_pkg::emit_type         emit,
   input  cnv_pkg::win_type          win,
   output logic [cnv_pkg::FPTR_W:0]  occ,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output cnv_pkg::rsp_word_type     rsp_data
);

   logic signed [cnv_pkg::COEF_W-1:0] coef_ff [cnv_pkg::COEF_NUM];

   logic signed [cnv_pkg::PROD_W-1:0]
      prod_ff [3][cnv_pkg::MAX_KERNEL][cnv_pkg::MAX_KERNEL];
   logic signed [cnv_pkg::PROD_W-1:0]
      prod_in [3][cnv_pkg::MAX_KERNEL][cnv_pkg::MAX_KERNEL];
   logic signed [cnv_pkg::RSUM_W-1:0] rsum_ff [3][cnv_pkg::MAX_KERNEL];
   logic signed [cnv_pkg::RSUM_W-1:0] rsum_in [3][cnv_pkg::MAX_KERNEL];
   logic signed [cnv_pkg::SUM_W-1:0]  total [3];
   logic [cnv_pkg::SUM_W-1:0]         shifted;
   logic [cnv_pkg::PIX_W-1:0]         pix [3];
   logic                              c_valid_ff, c_last_ff, d_valid_ff, d_last_ff;

   cnv_pkg::rsp_word_type             fifo_ff [cnv_pkg::FIFO_DEPTH];
   cnv_pkg::rsp_word_type             word;
   logic [cnv_pkg::FPTR_W-1:0]        rd_ptr_ff, wr_ptr_ff;
   logic [cnv_pkg::FPTR_W:0]          fcnt_ff, fcnt_in;
   logic                              push, pop;

   logic [cnv_pkg::CIDX_W:0]          cs;
   logic signed [cnv_pkg::COEF_W-1:0] coef;

   // tap products; taps outside the kernel are forced to zero
   always_comb begin
      for (int j = 0; j < cnv_pkg::MAX_KERNEL; j++) begin
         for (int i = 0; i < cnv_pkg::MAX_KERNEL; i++) begin
            cs   = cnv_pkg::coef_slot(j, i, geom.kernel);
            coef = cs[cnv_pkg::CIDX_W] ? coef_ff[cs[cnv_pkg::CIDX_W-1:0]] : '0;
            for (int ch = 0; ch < 3; ch++) begin
               if (cs[cnv_pkg::CIDX_W]) begin
                  prod_in[ch][j][i] = coef * $signed({1'b0,
                                      win[j][i][(2 - ch) * cnv_pkg::PIX_W +: cnv_pkg::PIX_W]});
               end else begin
                  prod_in[ch][j][i] = '0;
               end
            end
         end
      end
   end

   // row sums
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int j = 0; j < cnv_pkg::MAX_KERNEL; j++) begin
            rsum_in[ch][j] = '0;
            for (int i = 0; i < cnv_pkg::MAX_KERNEL; i++) begin
               rsum_in[ch][j] = rsum_in[ch][j] + cnv_pkg::RSUM_W'(prod_ff[ch][j][i]);
            end
         end
      end
   end

   // column of row sums, then floor and clamp
   always_comb begin
      shifted = '0;
      for (int ch = 0; ch < 3; ch++) begin
         total[ch] = '0;
         for (int j = 0; j < cnv_pkg::MAX_KERNEL; j++) begin
            total[ch] = total[ch] + cnv_pkg::SUM_W'(rsum_ff[ch][j]);
         end
         shifted = cnv_pkg::SUM_W'(total[ch] >>> cnv_pkg::COEF_FRAC_BITS);
         if (total[ch] < 0) begin
            pix[ch] = '0;
         end else if (shifted > cnv_pkg::SUM_W'(cnv_pkg::PIX_MAX)) begin
            pix[ch] = cnv_pkg::PIX_W'(cnv_pkg::PIX_MAX);
         end else begin
            pix[ch] = shifted[cnv_pkg::PIX_W-1:0];
         end
      end
      word.out_red    = pix[0];
      word.out_green  = pix[1];
      word.out_blue   = pix[2];
      word.frame_last = d_last_ff;
   end

   always_comb begin
      push      = d_valid_ff;
      rsp_empty = (fcnt_ff == '0);
      pop       = rsp_pop && !rsp_empty;
      fcnt_in   = fcnt_ff + (cnv_pkg::FPTR_W + 1)'(push) - (cnv_pkg::FPTR_W + 1)'(pop);
      occ       = fcnt_ff + (cnv_pkg::FPTR_W + 1)'(c_valid_ff)
                + (cnv_pkg::FPTR_W + 1)'(d_valid_ff);
   end

   assign rsp_data = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < cnv_pkg::COEF_NUM; n++) begin
            coef_ff[n] <= '0;
         end
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         fcnt_ff    <= '0;
      end else begin
         if (load.valid) begin
            coef_ff[load.index] <= load.value;
         end
         c_valid_ff <= emit.valid;
         d_valid_ff <= c_valid_ff;
         rd_ptr_ff  <= pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
         wr_ptr_ff  <= push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
         fcnt_ff    <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rsum_ff   <= rsum_in;
      c_last_ff <= emit.last;
      d_last_ff <= c_last_ff;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= word;
      end
   end

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= (cnv_pkg::FPTR_W + 1)'(cnv_pkg::FIFO_DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && fcnt_ff == (cnv_pkg::FPTR_W + 1)'(cnv_pkg::FIFO_DEPTH)))
      else $error("result written into a full queue");

endmodule

FILE: sv/rgb_conv2d_zero_pad_clamp_unit.sv
// RGB KxK convolution (K odd, up to 7) with zero padding outside the frame,
// per-channel floor and clamp to 0..255. Words go in as coefficient loads,
// pixels in raster order, or drain steps; each pixel or drain word yields at
// most one output pixel, in raster order, as soon as the input pad rows and
// pad columns beyond it has arrived. Drain words flush the tail of a frame.
// Rate: one input word per clock while req_full is low. An output at the
// start of a row fetches columns 0..pad of the line store (pad = K/2), one
// column per clock while the result queue has room, every other output a
// single column. Output words wait in an 8-deep result queue; the input
// side stalls (full) only when the command queue between front and back
// fills.
// The line store is eight 1024x24 RAMs, one per row; it is not cleared.
// Registers: 0 kernel size (0 acts as 1, even K as K-1), 1 image width
// (0 acts as 1, above 1024 as 1024), 2 image height (0 acts as 1). Write
// them only while the block is idle.
module rgb_conv2d_zero_pad_clamp_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  cnv_pkg::req_word_type       req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output cnv_pkg::rsp_word_type       rsp_data,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [cnv_pkg::HGT_W-1:0]   csr_data
);

   // config registers
   logic [cnv_pkg::KER_W-1:0] kernel_ff, kernel_in;
   logic [cnv_pkg::WID_W-1:0] width_ff, width_in;
   logic [cnv_pkg::HGT_W-1:0] height_ff, height_in;
   cnv_pkg::geom_type         geom;

   logic                      cmd_valid, cmd_pop;
   cnv_pkg::cmd_type          cmd_head;
   cnv_pkg::load_type         load;
   cnv_pkg::emit_type         emit;
   cnv_pkg::win_type          win;
   logic [cnv_pkg::FPTR_W:0]  mac_occ;

   always_comb begin
      kernel_in = kernel_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (cnv_pkg::csr_index_type'(csr_index))
            cnv_pkg::CSR_KERNEL: begin
               kernel_in = csr_data[cnv_pkg::KER_W-1:0];
            end
            cnv_pkg::CSR_WIDTH: begin
               width_in = csr_data[cnv_pkg::WID_W-1:0];
            end
            cnv_pkg::CSR_HEIGHT: begin
               height_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= cnv_pkg::KER_W'(3);
         width_ff  <= cnv_pkg::WID_W'(1024);
         height_ff <= cnv_pkg::HGT_W'(1024);
      end else begin
         kernel_ff <= kernel_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective geometry: odd kernel, width and height in range
   always_comb begin
      if (kernel_ff == '0) begin
         geom.kernel = cnv_pkg::KER_W'(1);
      end else if (!kernel_ff[0]) begin
         geom.kernel = kernel_ff - 1'b1;
      end else begin
         geom.kernel = kernel_ff;
      end
      geom.pad = cnv_pkg::PAD_W'(geom.kernel >> 1);
      if (width_ff == '0) begin
         geom.width = cnv_pkg::WID_W'(1);
      end else if (width_ff > cnv_pkg::WID_W'(cnv_pkg::MAX_WIDTH)) begin
         geom.width = cnv_pkg::WID_W'(cnv_pkg::MAX_WIDTH);
      end else begin
         geom.width = width_ff;
      end
      geom.height = (height_ff == '0) ? cnv_pkg::HGT_W'(1) : height_ff;
   end

   // front: positions, readiness, command queue
   cnv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop)
   );

   // back, part one: line store and 7x7 window
   cnv_window u_window (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .mac_occ   (mac_occ),
      .load      (load),
      .emit      (emit),
      .win       (win)
   );

   // back, part two: products, sums, clamp, result queue
   cnv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .load      (load),
      .emit      (emit),
      .win       (win),
      .occ       (mac_occ),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
